FILE: hw/rtl/min_tracking_stack_assert.svh
// Assertion macros for the min tracking stack.
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

`ifndef ASSERT_OFF

`define MTS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("min_tracking_stack: same-cycle check failed");

`define MTS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("min_tracking_stack: next-cycle check failed");

`else

`define MTS_ASSERT_IMPL(name, ante, cons)

`define MTS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: hw/rtl/mts_pkg.sv
// Shared types and codes for the min tracking stack.
`default_nettype none

package mts_pkg;

  localparam int VAL_W  = 32;
  localparam int DIFF_W = 33;
  localparam int FILL_W = 11;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [VAL_W-1:0]  value_t;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mts_in_if.sv
// Request channel: push or pop item with its value.
`default_nettype none

interface mts_in_if;
  logic              valid;
  logic              ready;
  mts_pkg::req_t     req_type;
  mts_pkg::value_t   push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mts_out_if.sv
// Result channel: top, minimum, fill state and status of each step.
`default_nettype none

interface mts_out_if;
  logic                          valid;
  logic                          ready;
  mts_pkg::value_t               top_value;
  mts_pkg::value_t               min_value;
  logic                          is_empty;
  logic [mts_pkg::FILL_W-1:0]    fill_count;
  mts_pkg::status_t              status;

  modport source (output valid, output top_value, output min_value, output is_empty,
                  output fill_count, output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input is_empty,
                  input fill_count, input status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mts_store.sv
// Difference store: single-port-write, registered-read memory of stack entries.
`default_nettype none

module mts_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  mts_pkg::diff_t      wr_data,
  input  logic [AW-1:0]       rd_addr,
  output mts_pkg::diff_t      rd_data
);
  import mts_pkg::*;

  diff_t mem [DEPTH];
  diff_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/min_tracking_stack.sv
// Min tracking stack: top entry held in a register, deeper entries in memory.
// Push: result registered in the cycle after accept. Pop leaving two or more entries: accept in
// ST_IDLE, then ST_RD for the registered store read of the new top entry, then result register.
// Pop to empty, pop on empty and push on full: result registered in the cycle after accept.
// Throughput: one item per cycle unless the result channel stalls; ST_RD takes no new request.
// Reset clears fill count, minimum and result valid; store contents stay undefined.
`default_nettype none

module min_tracking_stack #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  mts_in_if.sink     in_chan,
  mts_out_if.source  out_chan
);
  import mts_pkg::*;

  `include "min_tracking_stack_assert.svh"

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RD   = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  value_t            min_r, min_nxt;
  diff_t             top_r, top_nxt;
  logic              out_valid_r, out_valid_nxt;
  value_t            top_value_r, min_value_r;
  logic              is_empty_r;
  logic [FILL_W-1:0] fill_count_r;
  status_t           status_r;

  logic              in_ready;
  logic              acc;
  logic              load;
  value_t            res_top, res_min;
  status_t           res_status;
  logic [CW-1:0]     cnt_m1, cnt_m2;
  diff_t             push_diff;
  logic [CW+FILL_W-1:0] fill_ext;

  logic              mem_we;
  diff_t             mem_rdata;

  function automatic value_t recon(input value_t m, input diff_t d);
    value_t r;
    r = d[DIFF_W-1] ? m : (m + d[VAL_W-1:0]);
    return r;
  endfunction

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign acc       = in_chan.valid && in_ready;
  assign cnt_m1    = count_r - CW'(1);
  assign cnt_m2    = count_r - CW'(2);
  assign push_diff = {in_chan.push_value[VAL_W-1], in_chan.push_value}
                   - {min_r[VAL_W-1], min_r};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    top_nxt       = top_r;
    mem_we        = 1'b0;
    load          = 1'b0;
    res_top       = '0;
    res_min       = '0;
    res_status    = STAT_OK;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_chan.req_type == REQ_PUSH) begin
            load = 1'b1;
            if (count_r == CNT_FULL) begin
              res_status = STAT_PUSH_FULL;
              res_top    = recon(min_r, top_r);
              res_min    = min_r;
            end else if (count_r == '0) begin
              top_nxt   = '0;
              min_nxt   = in_chan.push_value;
              count_nxt = CW'(1);
              res_top   = in_chan.push_value;
              res_min   = in_chan.push_value;
            end else begin
              mem_we    = 1'b1;
              top_nxt   = push_diff;
              count_nxt = count_r + CW'(1);
              res_top   = in_chan.push_value;
              if (push_diff[DIFF_W-1]) begin
                min_nxt = in_chan.push_value;
                res_min = in_chan.push_value;
              end else begin
                res_min = min_r;
              end
            end
          end else begin
            if (count_r == '0) begin
              load       = 1'b1;
              res_status = STAT_POP_EMPTY;
            end else if (count_r == CW'(1)) begin
              load      = 1'b1;
              count_nxt = '0;
              min_nxt   = '0;
            end else begin
              count_nxt = cnt_m1;
              if (top_r[DIFF_W-1]) begin
                min_nxt = min_r - top_r[VAL_W-1:0];
              end
              state_nxt = ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        top_nxt   = mem_rdata;
        load      = 1'b1;
        res_top   = recon(min_r, mem_rdata);
        res_min   = min_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign fill_ext = {{FILL_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      min_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (load) begin
      top_value_r  <= res_top;
      min_value_r  <= res_min;
      is_empty_r   <= (count_nxt == '0);
      fill_count_r <= fill_ext[FILL_W-1:0];
      status_r     <= res_status;
    end
  end

  mts_store #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (cnt_m1[AW-1:0]),
    .wr_data (top_r),
    .rd_addr (cnt_m2[AW-1:0]),
    .rd_data (mem_rdata)
  );

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.top_value  = top_value_r;
  assign out_chan.min_value  = min_value_r;
  assign out_chan.is_empty   = is_empty_r;
  assign out_chan.fill_count = fill_count_r;
  assign out_chan.status     = status_r;

  `MTS_ASSERT_IMPL(a_cnt_bound, 1'b1, count_r <= CNT_FULL)
  `MTS_ASSERT_IMPL(a_empty_min, count_r == '0, min_r == '0)
  `MTS_ASSERT_IMPL(a_wr_on_push, mem_we, acc && in_chan.req_type == REQ_PUSH)
  `MTS_ASSERT_NEXT(a_pop_reads, acc && in_chan.req_type == REQ_POP && count_r > CW'(1), state_r == ST_RD && !out_valid_r)

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for min_tracking_stack: directed and random push/pops checked by a stack predictor.
module tb_top;
  import mts_pkg::*;

  localparam int STACK_DEPTH = 1024;
  localparam int WALK_ITEMS  = 850;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 2000;
  localparam value_t VMAX = 32'sh7fffffff;
  localparam value_t VMIN = 32'sh80000000;

  typedef struct packed {
    req_t   op;
    value_t value;
  } stack_req_t;

  typedef struct packed {
    value_t              top_value;
    value_t              min_value;
    logic                is_empty;
    logic [FILL_W-1:0]   fill_count;
    status_t             status;
  } stack_report_t;

  logic clk = 1'b0;
  logic rst_n;

  mts_in_if  req_ch ();
  mts_out_if rsp_ch ();

  min_tracking_stack #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_ch),
    .out_chan (rsp_ch)
  );

  always #5 clk = ~clk;

  stack_req_t    pending_reqs[$];
  stack_report_t step_reports[$];

  diff_t             diff_mem [STACK_DEPTH];
  value_t            run_min;
  logic [FILL_W-1:0] depth_used;

  int gen_fill;
  int mismatch_count;
  int send_wait;
  bit send_idle_on;
  int recv_wait;
  bit recv_idle_on;
  int hold_left;
  int results_seen;
  int stall_cycles;

  function automatic stack_report_t track_min_step(req_t op, value_t v);
    stack_report_t r;
    diff_t d;
    r.status = STAT_OK;
    if (op == REQ_PUSH) begin
      if (depth_used == STACK_DEPTH) begin
        r.status = STAT_PUSH_FULL;
      end else if (depth_used == 0) begin
        diff_mem[0] = '0;
        run_min = v;
        depth_used = 1;
      end else begin
        d = diff_t'(v) - diff_t'(run_min);
        diff_mem[depth_used] = d;
        if (d < 0) run_min = v;
        depth_used = depth_used + 1;
      end
    end else if (depth_used == 0) begin
      r.status = STAT_POP_EMPTY;
    end else begin
      d = diff_mem[depth_used - 1];
      depth_used = depth_used - 1;
      if (d < 0) run_min = value_t'(diff_t'(run_min) - d);
      if (depth_used == 0) run_min = '0;
    end
    r.top_value = '0;
    r.min_value = '0;
    if (depth_used != 0) begin
      d = diff_mem[depth_used - 1];
      r.min_value = run_min;
      r.top_value = (d < 0) ? run_min : value_t'(diff_t'(run_min) + d);
    end
    r.is_empty   = (depth_used == 0);
    r.fill_count = depth_used;
    return r;
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0: return VMAX;
      1: return VMIN;
      2, 3: return value_t'(int'($urandom_range(0, 16)) - 8);
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic queue_push(value_t v);
    pending_reqs.push_back('{REQ_PUSH, v});
    if (gen_fill < STACK_DEPTH) gen_fill++;
  endtask

  task automatic queue_pop();
    pending_reqs.push_back('{REQ_POP, value_t'($urandom)});
    if (gen_fill > 0) gen_fill--;
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    stack_req_t nxt;
    if (!rst_n) begin
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_PUSH;
      req_ch.push_value <= '0;
      send_wait         <= 0;
      send_idle_on      <= 1'b1;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        step_reports.push_back(track_min_step(req_ch.req_type, req_ch.push_value));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_wait != 0 || pending_reqs.size() == 0) begin
          req_ch.valid <= 1'b0;
          if (send_wait != 0) send_wait <= send_wait - 1;
        end else begin
          nxt = pending_reqs.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.req_type   <= nxt.op;
          req_ch.push_value <= nxt.value;
          send_wait         <= send_idle_on ? $urandom_range(0, 5) : 0;
          if ($urandom_range(0, 39) == 0) send_idle_on <= !send_idle_on;
        end
      end
    end
  end

  always @(posedge clk) begin
    stack_report_t exp_r;
    int w;
    bit got;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      recv_wait    <= 0;
      recv_idle_on <= 1'b1;
      hold_left    <= 0;
      results_seen <= 0;
    end else begin
      got = rsp_ch.valid && rsp_ch.ready;
      if (got) begin
        results_seen <= results_seen + 1;
        if (step_reports.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got top %0h", $time,
                   rsp_ch.top_value);
          mismatch_count++;
        end else begin
          exp_r = step_reports.pop_front();
          check_field("top_value", exp_r.top_value, rsp_ch.top_value);
          check_field("min_value", exp_r.min_value, rsp_ch.min_value);
          check_field("is_empty", exp_r.is_empty, rsp_ch.is_empty);
          check_field("fill_count", exp_r.fill_count, rsp_ch.fill_count);
          check_field("status", exp_r.status, rsp_ch.status);
        end
      end
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (got && results_seen == HOLD_AT) begin
        rsp_ch.ready <= 1'b0;
        hold_left    <= HOLD_CYCLES;
      end else if (got) begin
        w = recv_idle_on ? $urandom_range(0, 5) : 0;
        rsp_ch.ready <= (w == 0);
        recv_wait    <= w;
        if ($urandom_range(0, 39) == 0) recv_idle_on <= !recv_idle_on;
      end else if (recv_wait != 0) begin
        recv_wait    <= recv_wait - 1;
        rsp_ch.ready <= (recv_wait == 1);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int seg_len;
    int push_pct;
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_PUSH;
    req_ch.push_value = '0;
    rsp_ch.ready      = 1'b0;
    run_min           = '0;
    depth_used        = '0;
    gen_fill          = 0;
    mismatch_count    = 0;

    queue_pop();
    queue_push(5);
    queue_push(5);
    queue_push(7);
    queue_push(3);
    queue_push(VMAX);
    queue_push(VMIN);
    queue_push(VMIN);
    queue_push(VMAX);
    repeat (8) queue_pop();
    queue_pop();
    queue_push(VMIN);
    queue_push(VMAX);
    queue_pop();
    queue_pop();

    while (pending_reqs.size() < WALK_ITEMS) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: push_pct = 30;
        1: push_pct = 50;
        default: push_pct = 75;
      endcase
      repeat (seg_len) begin
        if ($urandom_range(1, 100) <= push_pct) queue_push(pick_value());
        else queue_pop();
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || step_reports.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
